FILE: sv/kmst_pkg.sv
`timescale 1ns / 1ps
package kmst_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VTX_W  = 6;
  localparam int WGT_W  = 16;
  localparam int TOT_W  = 22;
  localparam int VC_W   = 7;
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int IDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VID_W  = $clog2(MAX_VERTICES);
  localparam int RANK_W = 3;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(64);

  typedef struct packed {
    logic [VTX_W-1:0]        lo;
    logic [VTX_W-1:0]        hi;
    logic signed [WGT_W-1:0] w;
  } edge_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_B_INIT,
    OP_B_LD,
    OP_S_LDW,
    OP_S_RD,
    OP_S_CMP,
    OP_X_INIT,
    OP_X_LD,
    OP_X_SW,
    OP_K_CLR,
    OP_K_NEXT,
    OP_K_EDGE,
    OP_F_RD,
    OP_F_CHK,
    OP_C_RD,
    OP_C_CHK,
    OP_J_CMP,
    OP_J_UN,
    OP_PUSH,
    OP_FIN,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic bld_done;
    logic ext_done;
    logic sift_stop;
    logic ret_ext;
    logic clr_done;
    logic k_done;
    logic at_root;
    logic cmp_done;
    logic phase_hi;
    logic same_root;
    logic pend;
  } status_t;

endpackage

FILE: sv/kmst_intf.sv
`timescale 1ns / 1ps
interface kmst_edge_if;
  logic                      valid;
  logic                      ready;
  logic                      edge_present;
  logic [kmst_pkg::VTX_W-1:0] first_vertex;
  logic [kmst_pkg::VTX_W-1:0] second_vertex;
  logic signed [kmst_pkg::WGT_W-1:0] edge_weight;
  logic                      last_edge;

  modport source(output valid, edge_present, first_vertex, second_vertex, edge_weight,
                 last_edge, input ready);
  modport sink(input valid, edge_present, first_vertex, second_vertex, edge_weight,
               last_edge, output ready);
endinterface

interface kmst_tree_if;
  logic                      valid;
  logic                      ready;
  logic [kmst_pkg::VTX_W-1:0] tree_low_vertex;
  logic [kmst_pkg::VTX_W-1:0] tree_high_vertex;
  logic signed [kmst_pkg::WGT_W-1:0] tree_weight;
  logic signed [kmst_pkg::TOT_W-1:0] running_total;
  logic                      edge_found;
  logic                      store_overflow;
  logic                      last_result;

  modport source(output valid, tree_low_vertex, tree_high_vertex, tree_weight,
                 running_total, edge_found, store_overflow, last_result, input ready);
  modport sink(input valid, tree_low_vertex, tree_high_vertex, tree_weight,
               running_total, edge_found, store_overflow, last_result, output ready);
endinterface

FILE: sv/kmst_ctrl.sv
`timescale 1ns / 1ps
module kmst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  kmst_pkg::status_t st_i,
  output kmst_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BINIT  = 5'd1;
  localparam logic [4:0] S_BLD    = 5'd2;
  localparam logic [4:0] S_SLDW   = 5'd3;
  localparam logic [4:0] S_SRD    = 5'd4;
  localparam logic [4:0] S_SCMP   = 5'd5;
  localparam logic [4:0] S_XINIT  = 5'd6;
  localparam logic [4:0] S_XLD    = 5'd7;
  localparam logic [4:0] S_XSW    = 5'd8;
  localparam logic [4:0] S_KCLR   = 5'd9;
  localparam logic [4:0] S_KNEXT  = 5'd10;
  localparam logic [4:0] S_KEDGE  = 5'd11;
  localparam logic [4:0] S_FRD    = 5'd12;
  localparam logic [4:0] S_FCHK   = 5'd13;
  localparam logic [4:0] S_CRD    = 5'd14;
  localparam logic [4:0] S_CCHK   = 5'd15;
  localparam logic [4:0] S_JCMP   = 5'd16;
  localparam logic [4:0] S_JUN    = 5'd17;
  localparam logic [4:0] S_KPUSH  = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;
  localparam logic [4:0] S_FOUT   = 5'd20;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = kmst_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = kmst_pkg::OP_LOAD;
          if (in_last_i) state_d = S_BINIT;
        end
      end
      S_BINIT: begin
        cmd_o.op = kmst_pkg::OP_B_INIT;
        state_d  = st_i.n_small ? S_KCLR : S_BLD;
      end
      S_BLD: begin
        if (st_i.bld_done) begin
          state_d = S_XINIT;
        end else begin
          cmd_o.op = kmst_pkg::OP_B_LD;
          state_d  = S_SLDW;
        end
      end
      S_SLDW: begin
        cmd_o.op = kmst_pkg::OP_S_LDW;
        state_d  = S_SRD;
      end
      S_SRD: begin
        cmd_o.op = kmst_pkg::OP_S_RD;
        state_d  = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.op = kmst_pkg::OP_S_CMP;
        if (!st_i.sift_stop) state_d = S_SRD;
        else state_d = st_i.ret_ext ? S_XLD : S_BLD;
      end
      S_XINIT: begin
        cmd_o.op = kmst_pkg::OP_X_INIT;
        state_d  = S_XLD;
      end
      S_XLD: begin
        if (st_i.ext_done) begin
          state_d = S_KCLR;
        end else begin
          cmd_o.op = kmst_pkg::OP_X_LD;
          state_d  = S_XSW;
        end
      end
      S_XSW: begin
        cmd_o.op = kmst_pkg::OP_X_SW;
        state_d  = S_SRD;
      end
      S_KCLR: begin
        cmd_o.op = kmst_pkg::OP_K_CLR;
        if (st_i.clr_done) state_d = S_KNEXT;
      end
      S_KNEXT: begin
        if (st_i.k_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = kmst_pkg::OP_K_NEXT;
          state_d  = S_KEDGE;
        end
      end
      S_KEDGE: begin
        cmd_o.op = kmst_pkg::OP_K_EDGE;
        state_d  = S_FRD;
      end
      S_FRD: begin
        cmd_o.op = kmst_pkg::OP_F_RD;
        state_d  = S_FCHK;
      end
      S_FCHK: begin
        cmd_o.op = kmst_pkg::OP_F_CHK;
        state_d  = st_i.at_root ? S_CRD : S_FRD;
      end
      S_CRD: begin
        cmd_o.op = kmst_pkg::OP_C_RD;
        state_d  = S_CCHK;
      end
      S_CCHK: begin
        cmd_o.op = kmst_pkg::OP_C_CHK;
        if (!st_i.cmp_done) state_d = S_CRD;
        else state_d = st_i.phase_hi ? S_JCMP : S_FRD;
      end
      S_JCMP: begin
        cmd_o.op = kmst_pkg::OP_J_CMP;
        state_d  = st_i.same_root ? S_KNEXT : S_JUN;
      end
      S_JUN: begin
        cmd_o.op = kmst_pkg::OP_J_UN;
        state_d  = st_i.pend ? S_KPUSH : S_KNEXT;
      end
      S_KPUSH: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.op = kmst_pkg::OP_PUSH;
          state_d  = S_KNEXT;
        end
      end
      S_FIN: begin
        cmd_o.op = kmst_pkg::OP_FIN;
        state_d  = S_FOUT;
      end
      S_FOUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.op = kmst_pkg::OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

FILE: sv/kmst_dp.sv
`timescale 1ns / 1ps
module kmst_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kmst_pkg::cmd_t                    cmd_i,
  output kmst_pkg::status_t                 st_o,
  input  logic                              cfg_we_i,
  input  logic [kmst_pkg::VC_W-1:0]         cfg_data_i,
  input  logic                              edge_present_i,
  input  logic [kmst_pkg::VTX_W-1:0]        first_vertex_i,
  input  logic [kmst_pkg::VTX_W-1:0]        second_vertex_i,
  input  logic signed [kmst_pkg::WGT_W-1:0] edge_weight_i,
  input  logic                              last_edge_i,
  output logic [kmst_pkg::VTX_W-1:0]        tree_low_vertex_o,
  output logic [kmst_pkg::VTX_W-1:0]        tree_high_vertex_o,
  output logic signed [kmst_pkg::WGT_W-1:0] tree_weight_o,
  output logic signed [kmst_pkg::TOT_W-1:0] running_total_o,
  output logic                              edge_found_o,
  output logic                              store_overflow_o,
  output logic                              last_result_o
);

  localparam int CNT_W = kmst_pkg::CNT_W;
  localparam int IDX_W = kmst_pkg::IDX_W;
  localparam int VID_W = kmst_pkg::VID_W;
  localparam int VC_W  = kmst_pkg::VC_W;
  localparam int TOT_W = kmst_pkg::TOT_W;
  localparam int WGT_W = kmst_pkg::WGT_W;
  localparam int RK_W  = kmst_pkg::RANK_W;
  localparam int CW    = CNT_W + 1;

  // Edge store: one write port, two registered read ports.
  kmst_pkg::edge_t mem [kmst_pkg::MAX_EDGES];
  kmst_pkg::edge_t rda_q, rdb_q;
  logic            mwe;
  logic [IDX_W-1:0] mwa, mra, mrb;
  kmst_pkg::edge_t mwd;

  // Union-find tables.
  logic [VID_W-1:0] par [kmst_pkg::MAX_VERTICES];
  logic [RK_W-1:0]  rnk [kmst_pkg::MAX_VERTICES];
  logic             pwe, rwe;
  logic [VID_W-1:0] pwa, pwd, pra, rwa, rra, rrb;
  logic [RK_W-1:0]  rwd;
  logic [VID_W-1:0] prd_q;
  logic [RK_W-1:0]  rrx_q, rry_q;

  logic [VC_W-1:0]  vc_q;
  logic [CNT_W-1:0] cnt_q, n_q, bi_q, xj_q, size_q, ei_q;
  logic             ovf_q, ret_ext_q;
  logic [IDX_W-1:0] hole_q;
  kmst_pkg::edge_t  x_q, e_q;
  logic [VID_W-1:0] vclr_q, fr_q, fs_q, cv_q, xr_q, yr_q, kc_q;
  logic             phase_hi_q, pend_q;
  logic signed [TOT_W-1:0] tot_q, tot_d;

  kmst_pkg::edge_t         o_edge_q;
  logic signed [TOT_W-1:0] o_tot_q;
  logic                    o_found_q, o_last_q;

  logic [VC_W-1:0] nv;
  logic            keep, room;
  logic [CW-1:0]   lw, rw;
  logic            lok, rok;
  logic signed [WGT_W-1:0] bestw;
  logic [IDX_W-1:0] bigidx;
  kmst_pkg::edge_t  bigdat;

  assign nv = (vc_q > VC_W'(kmst_pkg::MAX_VERTICES)) ? VC_W'(kmst_pkg::MAX_VERTICES) : vc_q;
  assign keep = edge_present_i && (first_vertex_i != second_vertex_i)
                && (VC_W'(first_vertex_i) < nv) && (VC_W'(second_vertex_i) < nv);
  assign room = cnt_q < CNT_W'(kmst_pkg::MAX_EDGES);

  // Children of the current hole in the heap.
  assign lw    = CW'({hole_q, 1'b1});
  assign rw    = lw + CW'(1);
  assign lok   = (lw < CW'(size_q)) && ($signed(rda_q.w) > $signed(x_q.w));
  assign bestw = lok ? rda_q.w : x_q.w;
  assign rok   = (rw < CW'(size_q)) && ($signed(rdb_q.w) > $signed(bestw));
  assign bigidx = rok ? rw[IDX_W-1:0] : lw[IDX_W-1:0];
  assign bigdat = rok ? rdb_q : rda_q;

  assign tot_d = tot_q + {{(TOT_W-WGT_W){e_q.w[WGT_W-1]}}, e_q.w};

  always_comb begin
    st_o.n_small   = n_q < CNT_W'(2);
    st_o.bld_done  = bi_q == '0;
    st_o.ext_done  = xj_q == '0;
    st_o.sift_stop = !lok && !rok;
    st_o.ret_ext   = ret_ext_q;
    st_o.clr_done  = vclr_q == VID_W'(kmst_pkg::MAX_VERTICES - 1);
    st_o.k_done    = (ei_q == n_q) || ((VC_W'(kc_q) + VC_W'(1)) >= nv);
    st_o.at_root   = prd_q == fr_q;
    st_o.cmp_done  = prd_q == fr_q;
    st_o.phase_hi  = phase_hi_q;
    st_o.same_root = xr_q == yr_q;
    st_o.pend      = pend_q;
  end

  // Memory port steering.
  always_comb begin
    mwe = 1'b0;
    mwa = hole_q;
    mwd = x_q;
    mra = ei_q[IDX_W-1:0];
    mrb = xj_q[IDX_W-1:0];
    pwe = 1'b0;
    pwa = cv_q;
    pwd = fr_q;
    pra = fr_q;
    rwe = 1'b0;
    rwa = xr_q;
    rwd = rrx_q + RK_W'(1);
    rra = xr_q;
    rrb = yr_q;
    case (cmd_i.op)
      kmst_pkg::OP_LOAD: begin
        mwe = keep && room;
        mwa = cnt_q[IDX_W-1:0];
        mwd.lo = (first_vertex_i < second_vertex_i) ? first_vertex_i : second_vertex_i;
        mwd.hi = (first_vertex_i < second_vertex_i) ? second_vertex_i : first_vertex_i;
        mwd.w  = edge_weight_i;
      end
      kmst_pkg::OP_B_LD: mra = IDX_W'(bi_q - CNT_W'(1));
      kmst_pkg::OP_S_RD: begin
        mra = lw[IDX_W-1:0];
        mrb = rw[IDX_W-1:0];
      end
      kmst_pkg::OP_S_CMP: begin
        mwe = 1'b1;
        mwd = (lok || rok) ? bigdat : x_q;
      end
      kmst_pkg::OP_X_LD: mra = '0;
      kmst_pkg::OP_X_SW: begin
        mwe = 1'b1;
        mwa = xj_q[IDX_W-1:0];
        mwd = rda_q;
      end
      kmst_pkg::OP_K_CLR: begin
        pwe = 1'b1;
        pwa = vclr_q;
        pwd = vclr_q;
        rwe = 1'b1;
        rwa = vclr_q;
        rwd = '0;
      end
      kmst_pkg::OP_C_RD: pra = cv_q;
      kmst_pkg::OP_C_CHK: pwe = prd_q != fr_q;
      kmst_pkg::OP_J_UN: begin
        pwe = 1'b1;
        if (rrx_q < rry_q) begin
          pwa = xr_q;
          pwd = yr_q;
        end else begin
          pwa = yr_q;
          pwd = xr_q;
          rwe = rrx_q == rry_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mwe) mem[mwa] <= mwd;
    rda_q <= mem[mra];
    rdb_q <= mem[mrb];
    if (pwe) par[pwa] <= pwd;
    prd_q <= par[pra];
    if (rwe) rnk[rwa] <= rwd;
    rrx_q <= rnk[rra];
    rry_q <= rnk[rrb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= kmst_pkg::VC_RESET;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      vclr_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) vc_q <= cfg_data_i;
      case (cmd_i.op)
        kmst_pkg::OP_LOAD: begin
          if (keep && room) cnt_q <= cnt_q + CNT_W'(1);
          if (keep && !room) ovf_q <= 1'b1;
          if (last_edge_i) vclr_q <= '0;
        end
        kmst_pkg::OP_K_CLR: begin
          vclr_q <= vclr_q + VID_W'(1);
          pend_q <= 1'b0;
        end
        kmst_pkg::OP_J_UN: pend_q <= 1'b1;
        kmst_pkg::OP_DONE: begin
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
          pend_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      kmst_pkg::OP_LOAD: n_q <= cnt_q + CNT_W'(keep && room);
      kmst_pkg::OP_B_INIT: bi_q <= n_q >> 1;
      kmst_pkg::OP_B_LD: begin
        hole_q    <= IDX_W'(bi_q - CNT_W'(1));
        size_q    <= n_q;
        bi_q      <= bi_q - CNT_W'(1);
        ret_ext_q <= 1'b0;
      end
      kmst_pkg::OP_S_LDW: x_q <= rda_q;
      kmst_pkg::OP_S_CMP: if (lok || rok) hole_q <= bigidx;
      kmst_pkg::OP_X_INIT: xj_q <= n_q - CNT_W'(1);
      kmst_pkg::OP_X_SW: begin
        x_q       <= rdb_q;
        hole_q    <= '0;
        size_q    <= xj_q;
        xj_q      <= xj_q - CNT_W'(1);
        ret_ext_q <= 1'b1;
      end
      kmst_pkg::OP_K_CLR: begin
        ei_q  <= '0;
        kc_q  <= '0;
        tot_q <= '0;
      end
      kmst_pkg::OP_K_EDGE: begin
        e_q        <= rda_q;
        fr_q       <= VID_W'(rda_q.lo);
        fs_q       <= VID_W'(rda_q.lo);
        phase_hi_q <= 1'b0;
      end
      kmst_pkg::OP_F_CHK: begin
        if (prd_q != fr_q) fr_q <= prd_q;
        else cv_q <= fs_q;
      end
      kmst_pkg::OP_C_CHK: begin
        if (prd_q != fr_q) begin
          cv_q <= prd_q;
        end else if (!phase_hi_q) begin
          xr_q       <= fr_q;
          phase_hi_q <= 1'b1;
          fr_q       <= VID_W'(e_q.hi);
          fs_q       <= VID_W'(e_q.hi);
        end else begin
          yr_q <= fr_q;
        end
      end
      kmst_pkg::OP_J_CMP: if (xr_q == yr_q) ei_q <= ei_q + CNT_W'(1);
      kmst_pkg::OP_J_UN: begin
        tot_q <= tot_d;
        kc_q  <= kc_q + VID_W'(1);
        ei_q  <= ei_q + CNT_W'(1);
        if (!pend_q) begin
          o_edge_q  <= e_q;
          o_tot_q   <= tot_d;
          o_found_q <= 1'b1;
          o_last_q  <= 1'b0;
        end
      end
      kmst_pkg::OP_PUSH: begin
        o_edge_q  <= e_q;
        o_tot_q   <= tot_q;
        o_found_q <= 1'b1;
        o_last_q  <= 1'b0;
      end
      kmst_pkg::OP_FIN: begin
        o_last_q <= 1'b1;
        if (!pend_q) begin
          o_edge_q  <= '0;
          o_tot_q   <= '0;
          o_found_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign tree_low_vertex_o  = o_edge_q.lo;
  assign tree_high_vertex_o = o_edge_q.hi;
  assign tree_weight_o      = o_edge_q.w;
  assign running_total_o    = o_tot_q;
  assign edge_found_o       = o_found_q;
  assign store_overflow_o   = ovf_q;
  assign last_result_o      = o_last_q;

endmodule

FILE: sv/kruskal_mst_engine_top.sv
`timescale 1ns / 1ps
// Minimum spanning tree engine. Edges arrive as words on edge_in (valid/ready);
// a word is taken on a rising edge with valid and ready both high. Before the
// closing word, words are taken back to back: a legal edge is written to the
// edge store while it has room, with its endpoints ordered smaller first, and
// nothing is returned. The word marked last_edge starts the run: the store is
// heapsorted by weight in one shared edge memory (two reads and one write per
// cycle, with each sift level reading both children and then writing one), the
// union-find tables are cleared in a sweep over all 64 vertices, and Kruskal
// then walks the sorted edges, using find and path compression on parents.
// Tree edges leave on tree_out as words with a running total; the last word
// carries last_result, and an empty tree gives one word with edge_found low.
// One result word is held back until the next is known, so that the final one
// can be marked. When the receiver stalls, the engine simply waits with the
// word held steady. edge_in is not ready from the closing word until the
// final result word is taken.
// Reset clears the store count and overflow flag and sets vertex_count to 64;
// the memories are not cleared. vertex_count is written through cfg_we_i and
// cfg_data_i, by the user only between runs; the block does not enforce this.
module kruskal_mst_engine_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kmst_edge_if.sink                  edge_in,
  kmst_tree_if.source                tree_out,
  input  logic                       cfg_we_i,
  input  logic [kmst_pkg::VC_W-1:0]  cfg_data_i
);

  kmst_pkg::cmd_t    cmd;
  kmst_pkg::status_t st;

  // The controller sequences the sort and the tree search.
  kmst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (edge_in.valid),
    .in_last_i   (edge_in.last_edge),
    .in_ready_o  (edge_in.ready),
    .out_ready_i (tree_out.ready),
    .out_valid_o (tree_out.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // The datapath holds the edge store, union-find tables and result register.
  kmst_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .st_o               (st),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .edge_present_i     (edge_in.edge_present),
    .first_vertex_i     (edge_in.first_vertex),
    .second_vertex_i    (edge_in.second_vertex),
    .edge_weight_i      (edge_in.edge_weight),
    .last_edge_i        (edge_in.last_edge),
    .tree_low_vertex_o  (tree_out.tree_low_vertex),
    .tree_high_vertex_o (tree_out.tree_high_vertex),
    .tree_weight_o      (tree_out.tree_weight),
    .running_total_o    (tree_out.running_total),
    .edge_found_o       (tree_out.edge_found),
    .store_overflow_o   (tree_out.store_overflow),
    .last_result_o      (tree_out.last_result)
  );

`ifndef NO_ASSERTIONS
  // Input is never taken while a result word is offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(edge_in.ready && tree_out.valid))
    else $error("input ready while result pending");

  // An empty-tree word is always the final word of the run.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tree_out.valid && !tree_out.edge_found) |-> tree_out.last_result)
    else $error("empty result not marked last");

  // After the final word leaves, the engine takes input again.
  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tree_out.valid && tree_out.ready && tree_out.last_result) |=> edge_in.ready)
    else $error("engine not idle after final result");
`endif

endmodule
